[design/region_address_translator_unit_defines.svh]
// Assertion macros used by the region address translator checker.
`ifndef REGION_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH
`define REGION_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RAT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("region translator check failed");

// Next-cycle implication, disabled while reset is high.
`define RAT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("region translator check failed");

`endif

[design/rat_pkg.sv]
// Types, constants and codes of the region address translator.
`default_nettype none

package rat_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);

   localparam logic [31:0] VIRT_BASE_START = 32'h0010_0000;
   localparam logic [31:0] VIRT_ROUND_MASK = 32'h0000_03FF;

   localparam logic OP_MAP       = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   localparam logic [2:0] TYPE_BYTE   = 3'd0;
   localparam logic [2:0] TYPE_SHORT  = 3'd1;
   localparam logic [2:0] TYPE_JSHORT = 3'd2;
   localparam logic [2:0] TYPE_INT    = 3'd3;
   localparam logic [2:0] TYPE_JINT   = 3'd4;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_SIZE  = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_BAD_ADDR  = 3'd3;
   localparam logic [2:0] STATUS_BAD_TYPE  = 3'd4;

   typedef struct packed {
      logic              opcode;
      logic [31:0]       real_base;
      logic signed [31:0] region_size;
      logic [31:0]       virt_ptr;
      logic signed [31:0] ptr_offset;
      logic [2:0]        access_type;
      logic signed [31:0] store_value;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] mapped_virt_base;
      logic [31:0] real_addr;
      logic [31:0] memory_data;
      logic [2:0]  access_bytes;
      logic [31:0] advanced_ptr;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] virt_start;
      logic [31:0] real_start;
      logic [30:0] length;
   } region_entry_type;

   localparam int ENTRY_W = $bits(region_entry_type);

   typedef struct packed {
      logic        type_ok;
      logic [2:0]  bytes;
      logic [31:0] data;
   } fmt_result_type;

endpackage

`default_nettype wire

[design/rat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[design/rat_fmt.sv]
// Access sizing and write data ordering for one translate request.
`default_nettype none

module rat_fmt (
   input  wire logic [2:0]           access_type,
   input  wire logic [31:0]          store_value,
   input  wire logic                 little_endian,
   output rat_pkg::fmt_result_type   fmt
);

   always_comb begin
      fmt = '0;
      unique case (access_type)
         rat_pkg::TYPE_BYTE: begin
            fmt.type_ok = 1'b1;
            fmt.bytes   = 3'd1;
            fmt.data    = {24'h0, store_value[7:0]};
         end
         rat_pkg::TYPE_SHORT: begin
            fmt.type_ok = 1'b1;
            fmt.bytes   = 3'd2;
            fmt.data    = {16'h0, store_value[15:0]};
         end
         rat_pkg::TYPE_JSHORT: begin
            fmt.type_ok = 1'b1;
            fmt.bytes   = 3'd2;
            fmt.data    = little_endian ? {16'h0, store_value[7:0], store_value[15:8]}
                                        : {16'h0, store_value[15:0]};
         end
         rat_pkg::TYPE_INT: begin
            fmt.type_ok = 1'b1;
            fmt.bytes   = 3'd4;
            fmt.data    = store_value;
         end
         rat_pkg::TYPE_JINT: begin
            fmt.type_ok = 1'b1;
            fmt.bytes   = 3'd4;
            fmt.data    = little_endian ? {store_value[7:0], store_value[15:8],
                                           store_value[23:16], store_value[31:24]}
                                        : store_value;
         end
         default: begin
            fmt = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/region_address_translator_unit.sv]
// Region address translator: map requests pass through ST_MAP and ST_DONE from accept to result.
// Translate requests scan the region RAM one entry per cycle in map order:
//   a hit on entry i goes on through ST_FORM, and a miss over all n regions ends
//   in a bad-address result (also on an empty table).
// One request is in flight at a time; the result register frees the input side.
// Synchronous reset empties the table, sets the next virtual base to 0x100000
// and selects a little-endian host; the region RAM itself is not cleared.
`default_nettype none

module region_address_translator_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire rat_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rat_pkg::rsp_item_type      rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAP   = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_FORM  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   rat_pkg::req_item_type         req_ff, req_in;
   logic [31:0]                   addr_ff, addr_in;
   logic [rat_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [rat_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [31:0]                   nva_ff, nva_in;
   logic                          le_ff, le_in;
   logic [31:0]                   rel_ff, rel_in;
   logic [31:0]                   rstart_ff, rstart_in;
   rat_pkg::rsp_item_type         res_ff, res_in;
   rat_pkg::rsp_item_type         rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          wr_en;
   rat_pkg::region_entry_type     wr_entry;
   rat_pkg::region_entry_type     rd_entry;
   logic [rat_pkg::ENTRY_W-1:0]   rd_bits;
   rat_pkg::fmt_result_type       fmt;
   logic [31:0]                   size_bits;
   logic [31:0]                   rel;
   logic                          hit;
   logic [rat_pkg::CNT_W-1:0]     idx_next;

   // Entries are written only by map requests and read by later requests,
   // so a read never overlaps a pending write to the same entry.
   rat_ram #(
      .WIDTH (rat_pkg::ENTRY_W),
      .DEPTH (rat_pkg::MAX_REGIONS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[rat_pkg::IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (idx_in[rat_pkg::IDX_W-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_entry = rd_bits;

   rat_fmt u_fmt (
      .access_type   (req_ff.access_type),
      .store_value   (req_ff.store_value),
      .little_endian (le_ff),
      .fmt           (fmt)
   );

   assign size_bits = req_ff.region_size;
   assign rel       = addr_ff - rd_entry.virt_start;
   assign hit       = (idx_ff < cnt_ff) && (rel < {1'b0, rd_entry.length});
   assign idx_next  = idx_ff + rat_pkg::CNT_W'(1);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      nva_in       = nva_ff;
      le_in        = csr_wr_en ? csr_wr_data : le_ff;
      rel_in       = rel_ff;
      rstart_in    = rstart_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_entry     = '{virt_start: nva_ff, real_start: req_ff.real_base,
                       length: size_bits[30:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               addr_in = req_data.virt_ptr + req_data.ptr_offset;
               idx_in  = '0;
               state_in = (req_data.opcode == rat_pkg::OP_MAP) ? ST_MAP : ST_CHECK;
            end
         end
         ST_MAP: begin
            res_in = '0;
            priority if (size_bits[31] || size_bits == 32'h0) begin
               res_in.status = rat_pkg::STATUS_BAD_SIZE;
            end else if (cnt_ff >= rat_pkg::CNT_W'(rat_pkg::MAX_REGIONS)) begin
               res_in.status = rat_pkg::STATUS_FULL;
            end else begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + rat_pkg::CNT_W'(1);
               nva_in = (nva_ff + size_bits + rat_pkg::VIRT_ROUND_MASK)
                        & ~rat_pkg::VIRT_ROUND_MASK;
               res_in.status           = rat_pkg::STATUS_OK;
               res_in.mapped_virt_base = nva_ff;
            end
            state_in = ST_DONE;
         end
         ST_CHECK: begin
            priority if (hit) begin
               rel_in    = rel;
               rstart_in = rd_entry.real_start;
               state_in  = ST_FORM;
            end else if (idx_next >= cnt_ff) begin
               res_in              = '0;
               res_in.status       = rat_pkg::STATUS_BAD_ADDR;
               res_in.access_bytes = fmt.bytes;
               res_in.advanced_ptr = req_ff.virt_ptr + {29'h0, fmt.bytes};
               state_in            = ST_DONE;
            end else begin
               // advance to the next region in map order
               idx_in = idx_next;
            end
         end
         ST_FORM: begin
            res_in              = '0;
            res_in.status       = fmt.type_ok ? rat_pkg::STATUS_OK
                                              : rat_pkg::STATUS_BAD_TYPE;
            res_in.real_addr    = rstart_ff + rel_ff;
            res_in.memory_data  = fmt.data;
            res_in.access_bytes = fmt.bytes;
            res_in.advanced_ptr = req_ff.virt_ptr + {29'h0, fmt.bytes};
            state_in            = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         nva_ff       <= rat_pkg::VIRT_BASE_START;
         le_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nva_ff       <= nva_in;
         le_ff        <= le_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      addr_ff   <= addr_in;
      idx_ff    <= idx_in;
      rel_ff    <= rel_in;
      rstart_ff <= rstart_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

endmodule

`default_nettype wire

[design/rat_checker.sv]
// Port-level checks of the region address translator, bound to the top level.
`default_nettype none
`include "region_address_translator_unit_defines.svh"

module rat_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire rat_pkg::rsp_item_type rsp_data
);

   // a stalled result stays put
   `RAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `RAT_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_data.status == rat_pkg::STATUS_OK || rsp_data.status == rat_pkg::STATUS_BAD_SIZE || rsp_data.status == rat_pkg::STATUS_FULL || rsp_data.status == rat_pkg::STATUS_BAD_ADDR || rsp_data.status == rat_pkg::STATUS_BAD_TYPE)

   // failed requests never hand out a virtual base
   `RAT_ASSERT_NOW(a_fail_no_base, clock, reset, rsp_valid && rsp_data.status != rat_pkg::STATUS_OK, rsp_data.mapped_virt_base == 32'h0)

   `RAT_ASSERT_NOW(a_miss_empty, clock, reset, rsp_valid && rsp_data.status == rat_pkg::STATUS_BAD_ADDR, rsp_data.real_addr == 32'h0 && rsp_data.memory_data == 32'h0)

   `RAT_ASSERT_NOW(a_bytes_legal, clock, reset, rsp_valid, rsp_data.access_bytes == 3'd0 || rsp_data.access_bytes == 3'd1 || rsp_data.access_bytes == 3'd2 || rsp_data.access_bytes == 3'd4)

endmodule

bind region_address_translator_unit rat_checker u_rat_checker (.*);

`default_nettype wire
